// ===== design/cda_pkg.sv =====
// Shared codes, types and calendar helper functions of the calendar date arithmetic block.
package cda_pkg;

  localparam logic [2:0] CMD_ADD_MONTHS  = 3'd0;
  localparam logic [2:0] CMD_ADD_YEARS   = 3'd1;
  localparam logic [2:0] CMD_ADD_PERIOD  = 3'd2;
  localparam logic [2:0] CMD_BETWEEN     = 3'd3;
  localparam logic [2:0] CMD_DIFF_MONTHS = 3'd4;
  localparam logic [2:0] CMD_DIFF_YEARS  = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_INPUT  = 2'd1;
  localparam logic [1:0] ST_BAD_RESULT = 2'd2;

  localparam int SplitStages = 10;
  localparam int OpsStages   = 6;

  localparam logic signed [38:0] T_MIN = -39'sd62135596800;
  localparam logic signed [38:0] T_MAX = 39'sd253402300799;

  // Reciprocal of 100 for years below 2^14.
  localparam longint unsigned RecipY100 = ((64'd1 << 21) + 64'd99) / 64'd100;

  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] tod;
  } cda_date_t;

  function automatic logic is_leap(input logic [13:0] y);
    logic [35:0] p;
    logic [13:0] q;
    logic [13:0] r;
    p = 36'(y) * 36'(RecipY100);
    q = 14'(p >> 21);
    r = y - 14'(q * 14'd100);
    return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2: begin
        n = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = 5'd30;
      end
      default: begin
        n = 5'd31;
      end
    endcase
    return n;
  endfunction

  // Day of year of the first of a month, counted from March 1.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] n;
    case (mp)
      4'd0:    n = 9'd0;
      4'd1:    n = 9'd31;
      4'd2:    n = 9'd61;
      4'd3:    n = 9'd92;
      4'd4:    n = 9'd122;
      4'd5:    n = 9'd153;
      4'd6:    n = 9'd184;
      4'd7:    n = 9'd214;
      4'd8:    n = 9'd245;
      4'd9:    n = 9'd275;
      4'd10:   n = 9'd306;
      4'd11:   n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/cda_if.sv =====
// Request and response channel interfaces of the calendar date arithmetic block.
interface cda_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic signed [38:0] time_a;
  logic signed [38:0] time_b;
  logic signed [31:0] delta_years;
  logic signed [31:0] delta_months;
  logic signed [31:0] delta_days;

  modport source (
    output valid, cmd, time_a, time_b, delta_years, delta_months, delta_days,
    input  ready
  );
  modport sink (
    input  valid, cmd, time_a, time_b, delta_years, delta_months, delta_days,
    output ready
  );
endinterface

interface cda_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [48:0] time_out;
  logic signed [14:0] span_years;
  logic signed [4:0]  span_months;
  logic signed [5:0]  span_days;
  logic [16:0]        count_out;

  modport source (
    output valid, status, time_out, span_years, span_months, span_days, count_out,
    input  ready
  );
  modport sink (
    input  valid, status, time_out, span_years, span_months, span_days, count_out,
    output ready
  );
endinterface

// ===== design/cda_split.sv =====
// Pipeline that splits a Unix-second instant into a Gregorian date and a time of day.
module cda_split (
  input  logic                               clk_i,
  input  logic [cda_pkg::SplitStages-1:0]    en_i,
  input  logic signed [38:0]                 time_i,
  output cda_pkg::cda_date_t                 date_o
);
  import cda_pkg::*;

  localparam longint unsigned RecipDay  = (64'd1 << 41) / 64'd675;
  localparam longint unsigned RecipEra  = ((64'd1 << 40) + 64'd146096) / 64'd146097;
  localparam longint unsigned Recip1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
  localparam longint unsigned Recip36k  = ((64'd1 << 34) + 64'd36523) / 64'd36524;
  localparam longint unsigned Recip365  = ((64'd1 << 27) + 64'd364) / 64'd365;
  localparam longint unsigned RecipC100 = ((64'd1 << 16) + 64'd99) / 64'd100;
  localparam longint unsigned Recip153  = ((64'd1 << 19) + 64'd152) / 64'd153;

  // Stage 1: range check and offset to seconds since 0001-01-01.
  logic signed [39:0] u_full;
  logic        s1_ok_q;
  logic [38:0] s1_u_q;
  assign u_full = 40'(time_i) - 40'(T_MIN);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_ok_q <= (time_i >= T_MIN) && (time_i <= T_MAX);
      s1_u_q  <= u_full[38:0];
    end
  end

  // Stage 2: estimate of the day count, which is low by at most one.
  logic [63:0] s2_prod;
  logic        s2_ok_q;
  logic [38:0] s2_u_q;
  logic [21:0] s2_q0_q;
  assign s2_prod = 64'(s1_u_q[38:7]) * 64'(RecipDay);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_ok_q <= s1_ok_q;
      s2_u_q  <= s1_u_q;
      s2_q0_q <= s2_prod[62:41];
    end
  end

  // Stage 3: correct the day count.
  logic [31:0] s3_rem;
  logic        s3_ok_q;
  logic [38:0] s3_u_q;
  logic [21:0] s3_q_q;
  assign s3_rem = s2_u_q[38:7] - 32'(32'(s2_q0_q) * 32'd675);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_ok_q <= s2_ok_q;
      s3_u_q  <= s2_u_q;
      s3_q_q  <= s2_q0_q + 22'(s3_rem >= 32'd675);
    end
  end

  // Stage 4: time of day, and the 400-year era of the March-based day count.
  logic [21:0] s4_z;
  logic [63:0] s4_prod;
  logic        s4_ok_q;
  logic [16:0] s4_tod_q;
  logic [21:0] s4_z_q;
  logic [4:0]  s4_era_q;
  assign s4_z    = s3_q_q + 22'd306;
  assign s4_prod = 64'(s4_z) * 64'(RecipEra);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_ok_q  <= s3_ok_q;
      s4_tod_q <= 17'(s3_u_q - 39'(39'(s3_q_q) * 39'd86400));
      s4_z_q   <= s4_z;
      s4_era_q <= 5'(s4_prod >> 40);
    end
  end

  // Stage 5: day of the era.
  logic        s5_ok_q;
  logic [16:0] s5_tod_q;
  logic [4:0]  s5_era_q;
  logic [17:0] s5_doe_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_ok_q  <= s4_ok_q;
      s5_tod_q <= s4_tod_q;
      s5_era_q <= s4_era_q;
      s5_doe_q <= 18'(s4_z_q - 22'(22'(s4_era_q) * 22'd146097));
    end
  end

  // Stage 6: remove the leap days so that a plain divide by 365 gives the year.
  logic [17:0] s6_a1, s6_a2;
  logic        s6_ok_q;
  logic [16:0] s6_tod_q;
  logic [4:0]  s6_era_q;
  logic [17:0] s6_doe_q;
  logic [17:0] s6_n_q;
  assign s6_a1 = 18'((64'(s5_doe_q) * 64'(Recip1460)) >> 29);
  assign s6_a2 = 18'((64'(s5_doe_q) * 64'(Recip36k)) >> 34);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_ok_q  <= s5_ok_q;
      s6_tod_q <= s5_tod_q;
      s6_era_q <= s5_era_q;
      s6_doe_q <= s5_doe_q;
      s6_n_q   <= s5_doe_q - s6_a1 + s6_a2 - 18'(s5_doe_q == 18'd146096);
    end
  end

  // Stage 7: year of the era.
  logic        s7_ok_q;
  logic [16:0] s7_tod_q;
  logic [4:0]  s7_era_q;
  logic [17:0] s7_doe_q;
  logic [8:0]  s7_yoe_q;

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_ok_q  <= s6_ok_q;
      s7_tod_q <= s6_tod_q;
      s7_era_q <= s6_era_q;
      s7_doe_q <= s6_doe_q;
      s7_yoe_q <= 9'((64'(s6_n_q) * 64'(Recip365)) >> 27);
    end
  end

  // Stage 8: day of the March-based year.
  logic [8:0]  s8_c100;
  logic        s8_ok_q;
  logic [16:0] s8_tod_q;
  logic [4:0]  s8_era_q;
  logic [8:0]  s8_yoe_q;
  logic [8:0]  s8_doy_q;
  assign s8_c100 = 9'((64'(s7_yoe_q) * 64'(RecipC100)) >> 16);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s8_ok_q  <= s7_ok_q;
      s8_tod_q <= s7_tod_q;
      s8_era_q <= s7_era_q;
      s8_yoe_q <= s7_yoe_q;
      s8_doy_q <= 9'(s7_doe_q - (18'(s7_yoe_q) * 18'd365 + 18'(s7_yoe_q >> 2)
                  - 18'(s8_c100)));
    end
  end

  // Stage 9: March-based month.
  logic [10:0] s9_v;
  logic        s9_ok_q;
  logic [16:0] s9_tod_q;
  logic [4:0]  s9_era_q;
  logic [8:0]  s9_yoe_q;
  logic [8:0]  s9_doy_q;
  logic [3:0]  s9_mp_q;
  assign s9_v = 11'(s8_doy_q) * 11'd5 + 11'd2;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s9_ok_q  <= s8_ok_q;
      s9_tod_q <= s8_tod_q;
      s9_era_q <= s8_era_q;
      s9_yoe_q <= s8_yoe_q;
      s9_doy_q <= s8_doy_q;
      s9_mp_q  <= 4'((64'(s9_v) * 64'(Recip153)) >> 19);
    end
  end

  // Stage 10: calendar month, day and year.
  logic [3:0] s10_m;
  cda_date_t  date_q;
  assign s10_m = (s9_mp_q < 4'd10) ? s9_mp_q + 4'd3 : s9_mp_q - 4'd9;

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      date_q.ok    <= s9_ok_q;
      date_q.tod   <= s9_tod_q;
      date_q.month <= s10_m;
      date_q.day   <= 5'(s9_doy_q - month_start(s9_mp_q) + 9'd1);
      date_q.year  <= 14'(s9_yoe_q) + 14'(s9_era_q) * 14'd400 + 14'(s10_m <= 4'd2);
    end
  end

  assign date_o = date_q;

endmodule

// ===== design/calendar_date_arithmetic.sv =====
// Gregorian calendar date arithmetic on whole Unix-second instants.
// An item on req_i carries an operation code, two instants and signed year,
// month and day counts; each item gives exactly one item on rsp_o with a
// status and the result fields of the chosen operation (others read zero).
// The block is a 16-stage pipeline: ten stages turn each instant into a
// date and time of day, six more shift, measure and join dates again.
// One item can be accepted every cycle unless a stall has filled the pipeline.
// Each stage holds a valid bit and moves on when the stage after it is free,
// so a stall on rsp_o fills the empty stages first; req_i.ready falls only
// when every stage holds an item.
// Reset empties the pipeline; no result is lost or repeated under stalls.
module calendar_date_arithmetic (
  input logic       clk_i,
  input logic       rst_ni,
  cda_req_if.sink   req_i,
  cda_rsp_if.source rsp_o
);
  import cda_pkg::*;

  localparam int NumStages = SplitStages + OpsStages;
  localparam int P1 = SplitStages;
  localparam int P2 = SplitStages + 1;
  localparam int P3 = SplitStages + 2;
  localparam int P4 = SplitStages + 3;
  localparam int P5 = SplitStages + 4;
  localparam int P6 = SplitStages + 5;

  localparam longint unsigned Recip12  = ((64'd1 << 21) + 64'd11) / 64'd12;
  localparam longint unsigned Recip100 = ((64'd1 << 21) + 64'd99) / 64'd100;
  localparam longint unsigned Recip400 = ((64'd1 << 23) + 64'd399) / 64'd400;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] dy;
    logic [31:0] dm;
    logic [31:0] dd;
  } side_t;

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic [NumStages-1:0] vld_q, vld_d, en;

  assign en[NumStages-1] = !vld_q[NumStages-1] || rsp_o.ready;
  for (genvar k = 0; k < NumStages - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  assign vld_d = (en & {vld_q[NumStages-2:0], req_i.valid}) | (~en & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign req_i.ready = en[0];
  assign rsp_o.valid = vld_q[NumStages-1];

  // Request fields that travel beside the date split.
  side_t side_q [SplitStages];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= {req_i.cmd, req_i.delta_years, req_i.delta_months, req_i.delta_days};
    end
    for (int k = 1; k < SplitStages; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  cda_date_t date_a, date_b;

  cda_split u_split_a (
    .clk_i  (clk_i),
    .en_i   (en[SplitStages-1:0]),
    .time_i (req_i.time_a),
    .date_o (date_a)
  );

  cda_split u_split_b (
    .clk_i  (clk_i),
    .en_i   (en[SplitStages-1:0]),
    .time_i (req_i.time_b),
    .date_o (date_b)
  );

  side_t sd;
  assign sd = side_q[SplitStages-1];

  // P1: month indexes, month delta of the add operations, input checks.
  logic signed [36:0] p1_dy12;
  logic signed [37:0] p1_delta;
  logic               p1_big, p1_stin;

  assign p1_dy12 = (37'($signed(sd.dy)) <<< 3) + (37'($signed(sd.dy)) <<< 2);
  assign p1_big  = ($signed(sd.dy) > 32'sd100000) || ($signed(sd.dy) < -32'sd100000) ||
                   ($signed(sd.dm) > 32'sd1200000) || ($signed(sd.dm) < -32'sd1200000);

  always_comb begin
    case (sd.cmd)
      CMD_ADD_MONTHS: begin
        p1_delta = 38'($signed(sd.dm));
        p1_stin  = !date_a.ok;
      end
      CMD_ADD_YEARS: begin
        p1_delta = 38'(p1_dy12);
        p1_stin  = !date_a.ok;
      end
      CMD_ADD_PERIOD: begin
        p1_delta = 38'(p1_dy12) + 38'($signed(sd.dm));
        p1_stin  = !date_a.ok;
      end
      CMD_BETWEEN, CMD_DIFF_MONTHS, CMD_DIFF_YEARS: begin
        p1_delta = '0;
        p1_stin  = !(date_a.ok && date_b.ok);
      end
      default: begin
        p1_delta = '0;
        p1_stin  = 1'b0;
      end
    endcase
  end

  logic [2:0]         p1_cmd_q;
  logic               p1_stin_q, p1_big_q, p1_bleap_q;
  logic [16:0]        p1_idx_a_q, p1_idx_b_q;
  logic signed [37:0] p1_delta_q;
  logic signed [5:0]  p1_dday_q;
  logic [4:0]         p1_aday_q, p1_bday_q;
  logic [16:0]        p1_tod_q;
  logic [13:0]        p1_ayear_q, p1_byear_q;
  logic [3:0]         p1_bmonth_q;
  logic [31:0]        p1_dd_q;

  always_ff @(posedge clk_i) begin
    if (en[P1]) begin
      p1_cmd_q    <= sd.cmd;
      p1_stin_q   <= p1_stin;
      p1_big_q    <= (sd.cmd == CMD_ADD_PERIOD) && p1_big;
      p1_idx_a_q  <= 17'(date_a.year) * 17'd12 + 17'(date_a.month) - 17'd1;
      p1_idx_b_q  <= 17'(date_b.year) * 17'd12 + 17'(date_b.month) - 17'd1;
      p1_delta_q  <= p1_delta;
      p1_dday_q   <= $signed({1'b0, date_b.day}) - $signed({1'b0, date_a.day});
      p1_aday_q   <= date_a.day;
      p1_bday_q   <= date_b.day;
      p1_tod_q    <= date_a.tod;
      p1_ayear_q  <= date_a.year;
      p1_byear_q  <= date_b.year;
      p1_bmonth_q <= date_b.month;
      p1_bleap_q  <= is_leap(date_b.year);
      p1_dd_q     <= sd.dd;
    end
  end

  // P2: target month index and its range, span with borrow, counts.
  logic signed [37:0] p2_tot;
  logic               p2_rng_ok, p2_bdn, p2_bup;
  logic signed [17:0] p2_mt;
  logic signed [14:0] p2_yd;
  logic [3:0]         p2_pm;
  logic [4:0]         p2_pl, p2_bl, p2_amin;
  logic signed [5:0]  p2_sd;
  logic [16:0]        p2_cnt;
  logic [1:0]         p2_stat;

  assign p2_tot    = $signed(38'(p1_idx_a_q)) + p1_delta_q;
  assign p2_rng_ok = (p2_tot >= 38'sd12) && (p2_tot <= 38'sd119999);
  assign p2_mt     = $signed(18'(p1_idx_b_q)) - $signed(18'(p1_idx_a_q));
  assign p2_yd     = $signed({1'b0, p1_ayear_q}) - $signed({1'b0, p1_byear_q});
  assign p2_bdn    = (p2_mt > 18'sd0) && (p1_dday_q < 6'sd0);
  assign p2_bup    = (p2_mt < 18'sd0) && (p1_dday_q > 6'sd0);
  assign p2_pm     = (p1_bmonth_q == 4'd1) ? 4'd12 : p1_bmonth_q - 4'd1;
  assign p2_pl     = days_in(p2_pm, p1_bleap_q);
  assign p2_bl     = days_in(p1_bmonth_q, p1_bleap_q);
  assign p2_amin   = (p1_aday_q < p2_pl) ? p1_aday_q : p2_pl;

  always_comb begin
    if (p2_bdn) begin
      // Days left in the month before the end date, plus the end date's day.
      p2_sd = $signed(6'(p2_pl) - 6'(p2_amin) + 6'(p1_bday_q));
    end else if (p2_bup) begin
      p2_sd = p1_dday_q - $signed({1'b0, p2_bl});
    end else begin
      p2_sd = p1_dday_q;
    end
  end

  always_comb begin
    case (p1_cmd_q)
      CMD_DIFF_MONTHS: p2_cnt = p2_mt[17] ? 17'(-p2_mt) : 17'(p2_mt);
      CMD_DIFF_YEARS:  p2_cnt = p2_yd[14] ? 17'(-p2_yd) : 17'(p2_yd);
      default:         p2_cnt = '0;
    endcase
  end

  always_comb begin
    if (p1_stin_q) begin
      p2_stat = ST_BAD_INPUT;
    end else begin
      case (p1_cmd_q)
        CMD_ADD_MONTHS, CMD_ADD_YEARS: begin
          p2_stat = p2_rng_ok ? ST_OK : ST_BAD_RESULT;
        end
        CMD_ADD_PERIOD: begin
          p2_stat = (p2_rng_ok && !p1_big_q) ? ST_OK : ST_BAD_RESULT;
        end
        default: begin
          p2_stat = ST_OK;
        end
      endcase
    end
  end

  logic [2:0]         p2_cmd_q;
  logic [1:0]         p2_stat_q;
  logic [16:0]        p2_tot_q;
  logic [4:0]         p2_aday_q;
  logic [16:0]        p2_tod_q;
  logic [31:0]        p2_dd_q;
  logic signed [17:0] p2_mt_q;
  logic signed [5:0]  p2_sd_q;
  logic [16:0]        p2_cnt_q;

  always_ff @(posedge clk_i) begin
    if (en[P2]) begin
      p2_cmd_q  <= p1_cmd_q;
      p2_stat_q <= p2_stat;
      p2_tot_q  <= p2_tot[16:0];
      p2_aday_q <= p1_aday_q;
      p2_tod_q  <= p1_tod_q;
      p2_dd_q   <= p1_dd_q;
      p2_mt_q   <= p2_mt - 18'(p2_bdn) + 18'(p2_bup);
      p2_sd_q   <= p2_sd;
      p2_cnt_q  <= p2_cnt;
    end
  end

  // P3: month index to year and month; span months to years and months.
  logic [13:0] p3_ny, p3_sq;
  logic [3:0]  p3_nm0, p3_sr;
  logic        p3_neg;
  logic [16:0] p3_mag;

  assign p3_ny  = 14'((64'(p2_tot_q) * 64'(Recip12)) >> 21);
  assign p3_nm0 = 4'(p2_tot_q - 17'(p3_ny) * 17'd12);
  assign p3_neg = p2_mt_q[17];
  assign p3_mag = p3_neg ? 17'(-p2_mt_q) : 17'(p2_mt_q);
  assign p3_sq  = 14'((64'(p3_mag) * 64'(Recip12)) >> 21);
  assign p3_sr  = 4'(p3_mag - 17'(p3_sq) * 17'd12);

  logic [2:0]         p3_cmd_q;
  logic [1:0]         p3_stat_q;
  logic [13:0]        p3_ny_q;
  logic [3:0]         p3_nm_q;
  logic [4:0]         p3_aday_q;
  logic [16:0]        p3_tod_q;
  logic [31:0]        p3_dd_q;
  logic signed [14:0] p3_sy_q;
  logic signed [4:0]  p3_smo_q;
  logic signed [5:0]  p3_sd_q;
  logic [16:0]        p3_cnt_q;

  always_ff @(posedge clk_i) begin
    if (en[P3]) begin
      p3_cmd_q  <= p2_cmd_q;
      p3_stat_q <= p2_stat_q;
      p3_ny_q   <= p3_ny;
      p3_nm_q   <= p3_nm0 + 4'd1;
      p3_aday_q <= p2_aday_q;
      p3_tod_q  <= p2_tod_q;
      p3_dd_q   <= p2_dd_q;
      p3_sy_q   <= p3_neg ? -$signed(15'(p3_sq)) : $signed(15'(p3_sq));
      p3_smo_q  <= p3_neg ? -$signed(5'(p3_sr)) : $signed(5'(p3_sr));
      p3_sd_q   <= p2_sd_q;
      p3_cnt_q  <= p2_cnt_q;
    end
  end

  // P4: clamp the day to the target month, March-based year and day of year.
  logic [4:0] p4_lim, p4_nd;
  logic [3:0] p4_mp;

  assign p4_lim = days_in(p3_nm_q, is_leap(p3_ny_q));
  assign p4_nd  = (p3_aday_q < p4_lim) ? p3_aday_q : p4_lim;
  assign p4_mp  = (p3_nm_q > 4'd2) ? p3_nm_q - 4'd3 : p3_nm_q + 4'd9;

  logic [2:0]         p4_cmd_q;
  logic [1:0]         p4_stat_q;
  logic [13:0]        p4_yy_q;
  logic [8:0]         p4_base_q;
  logic [16:0]        p4_tod_q;
  logic [31:0]        p4_dd_q;
  logic signed [14:0] p4_sy_q;
  logic signed [4:0]  p4_smo_q;
  logic signed [5:0]  p4_sd_q;
  logic [16:0]        p4_cnt_q;

  always_ff @(posedge clk_i) begin
    if (en[P4]) begin
      p4_cmd_q  <= p3_cmd_q;
      p4_stat_q <= p3_stat_q;
      p4_yy_q   <= p3_ny_q - 14'(p3_nm_q <= 4'd2);
      p4_base_q <= month_start(p4_mp) + 9'(p4_nd) - 9'd1;
      p4_tod_q  <= p3_tod_q;
      p4_dd_q   <= p3_dd_q;
      p4_sy_q   <= p3_sy_q;
      p4_smo_q  <= p3_smo_q;
      p4_sd_q   <= p3_sd_q;
      p4_cnt_q  <= p3_cnt_q;
    end
  end

  // P5: day number relative to 1970-01-01, plus the day count of the period operation.
  logic [13:0] p5_q100, p5_q400;
  logic [33:0] p5_days, p5_extra;

  assign p5_q100  = 14'((64'(p4_yy_q) * 64'(Recip100)) >> 21);
  assign p5_q400  = 14'((64'(p4_yy_q) * 64'(Recip400)) >> 23);
  assign p5_days  = 34'(22'(p4_yy_q) * 22'd365) + 34'(p4_yy_q >> 2) - 34'(p5_q100)
                  + 34'(p5_q400) + 34'(p4_base_q) - 34'd719468;
  assign p5_extra = (p4_cmd_q == CMD_ADD_PERIOD) ? 34'($signed(p4_dd_q)) : '0;

  logic [2:0]         p5_cmd_q;
  logic [1:0]         p5_stat_q;
  logic [33:0]        p5_eday_q;
  logic [16:0]        p5_tod_q;
  logic signed [14:0] p5_sy_q;
  logic signed [4:0]  p5_smo_q;
  logic signed [5:0]  p5_sd_q;
  logic [16:0]        p5_cnt_q;

  always_ff @(posedge clk_i) begin
    if (en[P5]) begin
      p5_cmd_q  <= p4_cmd_q;
      p5_stat_q <= p4_stat_q;
      p5_eday_q <= p5_days + p5_extra;
      p5_tod_q  <= p4_tod_q;
      p5_sy_q   <= p4_sy_q;
      p5_smo_q  <= p4_smo_q;
      p5_sd_q   <= p4_sd_q;
      p5_cnt_q  <= p4_cnt_q;
    end
  end

  // P6: seconds of the result instant, and field masking by status and operation.
  logic [51:0] p6_secs;
  logic        p6_ok, p6_is_add, p6_is_span;

  assign p6_secs    = 52'($signed(p5_eday_q)) * 52'd86400 + 52'(p5_tod_q);
  assign p6_ok      = (p5_stat_q == ST_OK);
  assign p6_is_add  = (p5_cmd_q == CMD_ADD_MONTHS) || (p5_cmd_q == CMD_ADD_YEARS) ||
                      (p5_cmd_q == CMD_ADD_PERIOD);
  assign p6_is_span = (p5_cmd_q == CMD_BETWEEN);

  logic [1:0]         out_stat_q;
  logic signed [48:0] out_time_q;
  logic signed [14:0] out_sy_q;
  logic signed [4:0]  out_smo_q;
  logic signed [5:0]  out_sd_q;
  logic [16:0]        out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (en[P6]) begin
      out_stat_q <= p5_stat_q;
      out_time_q <= (p6_ok && p6_is_add) ? $signed(p6_secs[48:0]) : '0;
      out_sy_q   <= (p6_ok && p6_is_span) ? p5_sy_q : '0;
      out_smo_q  <= (p6_ok && p6_is_span) ? p5_smo_q : '0;
      out_sd_q   <= (p6_ok && p6_is_span) ? p5_sd_q : '0;
      out_cnt_q  <= p6_ok ? p5_cnt_q : '0;
    end
  end

  assign rsp_o.status      = out_stat_q;
  assign rsp_o.time_out    = out_time_q;
  assign rsp_o.span_years  = out_sy_q;
  assign rsp_o.span_months = out_smo_q;
  assign rsp_o.span_days   = out_sd_q;
  assign rsp_o.count_out   = out_cnt_q;

endmodule

// ===== tb/calendar_date_arithmetic_tb.sv =====
// Self-checking testbench of the calendar date arithmetic block.
module calendar_date_arithmetic_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cda_pkg::*;

  localparam longint TMin = -64'sd62135596800;
  localparam longint TMax = 64'sd253402300799;
  localparam longint SecPerDay = 86400;

  typedef struct {
    logic [1:0]         status;
    logic signed [48:0] time_out;
    logic signed [14:0] span_years;
    logic signed [4:0]  span_months;
    logic signed [5:0]  span_days;
    logic [16:0]        count_out;
  } calc_result_t;

  typedef struct {
    longint y;
    longint m;
    longint d;
    longint tod;
  } civil_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cda_req_if req_if ();
  cda_rsp_if rsp_if ();

  calendar_date_arithmetic u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  calc_result_t expected_q[$];
  int  n_errors = 0;
  int  n_results = 0;
  int  n_sent = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  int  sink_hold = 0;
  int  hold_cnt = 0;

  // ---------------- calendar predictor ----------------
  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint month_days(longint m, longint y);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, doy, doe;
    yy = y - ((m <= 2) ? 1 : 0);
    era = ((yy >= 0) ? yy : yy - 399) / 400;
    yoe = yy - era * 400;
    doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic bit to_civil(longint t, output civil_t c);
    longint days, rem, z, era, doe, yoe, doy, mp;
    c = '{default: 0};
    if (t < TMin || t > TMax) return 1'b0;
    days = t / SecPerDay;
    rem = t % SecPerDay;
    if (rem < 0) begin
      rem += SecPerDay;
      days -= 1;
    end
    z = days + 719468;
    era = ((z >= 0) ? z : z - 146096) / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    c.d = doy - (153 * mp + 2) / 5 + 1;
    c.m = (mp < 10) ? mp + 3 : mp - 9;
    c.y = yoe + era * 400 + ((c.m <= 2) ? 1 : 0);
    c.tod = rem;
    return 1'b1;
  endfunction

  function automatic bit move_months(civil_t src, longint delta, output civil_t dst);
    longint total, ny, nm, lim;
    dst = src;
    total = src.y * 12 + (src.m - 1) + delta;
    ny = total / 12;
    nm = total % 12;
    if (nm < 0) begin
      nm += 12;
      ny -= 1;
    end
    if (ny < 1 || ny > 9999) return 1'b0;
    dst.y = ny;
    dst.m = nm + 1;
    lim = month_days(dst.m, ny);
    dst.d = (src.d < lim) ? src.d : lim;
    return 1'b1;
  endfunction

  function automatic longint civil_seconds(civil_t c);
    return day_number(c.y, c.m, c.d) * SecPerDay + c.tod;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic calc_result_t date_calc(logic [2:0] cmd, longint ta, longint tb,
                                             longint dy, longint dm, longint dd);
    calc_result_t res;
    civil_t a, b, r;
    bit a_ok, b_ok;
    longint st, tout, sy, smo, sd, cnt, total, days, ny;
    st = 0; tout = 0; sy = 0; smo = 0; sd = 0; cnt = 0;
    a_ok = to_civil(ta, a);
    b_ok = to_civil(tb, b);
    if (cmd <= CMD_ADD_PERIOD && !a_ok) begin
      st = ST_BAD_INPUT;
    end else if (cmd >= CMD_BETWEEN && cmd <= CMD_DIFF_YEARS && !(a_ok && b_ok)) begin
      st = ST_BAD_INPUT;
    end else if (cmd == CMD_ADD_MONTHS) begin
      if (move_months(a, dm, r)) tout = civil_seconds(r);
      else st = ST_BAD_RESULT;
    end else if (cmd == CMD_ADD_YEARS) begin
      ny = a.y + dy;
      if (ny < 1 || ny > 9999) begin
        st = ST_BAD_RESULT;
      end else begin
        r = a;
        r.y = ny;
        if (a.m == 2 && a.d == 29 && !leap_year(ny)) r.d = 28;
        tout = civil_seconds(r);
      end
    end else if (cmd == CMD_ADD_PERIOD) begin
      if (abs_l(dy) > 100000 || abs_l(dm) > 1200000 || !move_months(a, dy * 12 + dm, r))
        st = ST_BAD_RESULT;
      else
        tout = civil_seconds(r) + dd * SecPerDay;
    end else if (cmd == CMD_BETWEEN) begin
      total = (b.y * 12 + (b.m - 1)) - (a.y * 12 + (a.m - 1));
      days = b.d - a.d;
      if (total > 0 && days < 0) begin
        total -= 1;
        if (move_months(a, total, r))
          days = day_number(b.y, b.m, b.d) - day_number(r.y, r.m, r.d);
        else
          st = ST_BAD_RESULT;
      end else if (total < 0 && days > 0) begin
        total += 1;
        days -= month_days(b.m, b.y);
      end
      if (st == 0) begin
        sy = total / 12;
        smo = total % 12;
        sd = days;
      end
    end else if (cmd == CMD_DIFF_MONTHS) begin
      cnt = abs_l((a.y * 12 + a.m) - (b.y * 12 + b.m));
    end else if (cmd == CMD_DIFF_YEARS) begin
      cnt = abs_l(a.y - b.y);
    end
    if (st != 0) begin
      tout = 0; sy = 0; smo = 0; sd = 0; cnt = 0;
    end
    res.status = st[1:0];
    res.time_out = tout[48:0];
    res.span_years = sy[14:0];
    res.span_months = smo[4:0];
    res.span_days = sd[5:0];
    res.count_out = cnt[16:0];
    return res;
  endfunction

  // ---------------- driving ----------------
  // Valid stays high from one accepted item to the next unless the sender idles.
  task automatic send_request(logic [2:0] cmd, longint ta, longint tb,
                              longint dy, longint dm, longint dd);
    while (src_idle_on && $urandom_range(99) < 33) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.time_a <= ta[38:0];
    req_if.time_b <= tb[38:0];
    req_if.delta_years <= dy[31:0];
    req_if.delta_months <= dm[31:0];
    req_if.delta_days <= dd[31:0];
    expected_q.push_back(date_calc(cmd, $signed(ta[38:0]), $signed(tb[38:0]),
                                   $signed(dy[31:0]), $signed(dm[31:0]),
                                   $signed(dd[31:0])));
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long counted hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt < sink_hold) begin
      hold_cnt <= hold_cnt + 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !(sink_idle_on && $urandom_range(99) < 33);
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    calc_result_t exp_r;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item, status %0d", rsp_if.status);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (rsp_if.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_if.status);
          n_errors++;
        end
        if (rsp_if.time_out !== exp_r.time_out) begin
          $error("time_out: expected %0d, got %0d", exp_r.time_out, rsp_if.time_out);
          n_errors++;
        end
        if (rsp_if.span_years !== exp_r.span_years) begin
          $error("span_years: expected %0d, got %0d", exp_r.span_years, rsp_if.span_years);
          n_errors++;
        end
        if (rsp_if.span_months !== exp_r.span_months) begin
          $error("span_months: expected %0d, got %0d", exp_r.span_months,
                 rsp_if.span_months);
          n_errors++;
        end
        if (rsp_if.span_days !== exp_r.span_days) begin
          $error("span_days: expected %0d, got %0d", exp_r.span_days, rsp_if.span_days);
          n_errors++;
        end
        if (rsp_if.count_out !== exp_r.count_out) begin
          $error("count_out: expected %0d, got %0d", exp_r.count_out, rsp_if.count_out);
          n_errors++;
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic longint rand_instant();
    longint span;
    span = TMax - TMin;
    return TMin + ((longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF) % (span + 1));
  endfunction

  // Instant on a chosen date, used to hit month ends and leap days.
  function automatic longint date_instant(longint y, longint m, longint d);
    return day_number(y, m, d) * SecPerDay + $urandom_range(86399);
  endfunction

  function automatic longint rand_word();
    return longint'($signed($urandom));
  endfunction

  function automatic longint near_instant();
    longint y;
    y = $urandom_range(9999, 1);
    return date_instant(y, $urandom_range(12, 1),
                        ($urandom_range(3) == 0) ? 29 + $urandom_range(2) : $urandom_range(28, 1));
  endfunction

  function automatic longint clamp_day(longint y, longint m, longint d);
    return (d > month_days(m, y)) ? month_days(m, y) : d;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    longint leap_day;
    leap_day = date_instant(2024, 2, 29);
    send_request(CMD_ADD_MONTHS, TMin, 0, 0, 0, 0);
    send_request(CMD_ADD_MONTHS, TMax, 0, 0, 1, 0);
    send_request(CMD_ADD_MONTHS, TMin - 1, 0, 0, 0, 0);
    send_request(CMD_ADD_MONTHS, TMax + 1, 0, 0, 0, 0);
    send_request(CMD_ADD_MONTHS, date_instant(2023, 1, 31), 0, 0, 1, 0);
    send_request(CMD_ADD_MONTHS, TMin, 0, 0, -1, 0);
    send_request(CMD_ADD_YEARS, leap_day, 0, 1, 0, 0);
    send_request(CMD_ADD_YEARS, leap_day, 0, 4, 0, 0);
    send_request(CMD_ADD_YEARS, TMax, 0, 1, 0, 0);
    send_request(CMD_ADD_YEARS, 0, 0, -64'sd2147483648, 0, 0);
    send_request(CMD_ADD_PERIOD, 0, 0, 100000, 0, 0);
    send_request(CMD_ADD_PERIOD, 0, 0, 100001, 0, 0);
    send_request(CMD_ADD_PERIOD, 0, 0, 0, -1200001, 0);
    send_request(CMD_ADD_PERIOD, TMax, 0, 0, 0, 64'sd2147483647);
    send_request(CMD_ADD_PERIOD, TMin, 0, 0, 0, -64'sd2147483648);
    send_request(CMD_ADD_PERIOD, leap_day, 0, 1, 1, -1);
    send_request(CMD_BETWEEN, TMin, TMax, 0, 0, 0);
    send_request(CMD_BETWEEN, TMax, TMin, 0, 0, 0);
    send_request(CMD_BETWEEN, date_instant(2023, 1, 31), date_instant(2023, 3, 1), 0, 0, 0);
    send_request(CMD_BETWEEN, date_instant(2023, 3, 31), date_instant(2023, 1, 1), 0, 0, 0);
    send_request(CMD_BETWEEN, 0, TMax + 1, 0, 0, 0);
    send_request(CMD_DIFF_MONTHS, TMin, TMax, 0, 0, 0);
    send_request(CMD_DIFF_YEARS, TMax, TMin, 0, 0, 0);
    send_request(CMD_DIFF_YEARS, TMin - 1, 0, 0, 0, 0);
    send_request(3'd6, rand_instant(), rand_instant(), 1, 1, 1);
    send_request(3'd7, -64'sd274877906944, 64'sd274877906943, -1, -1, -1);
  endtask

  task automatic test_random(int n);
    logic [2:0] cmd;
    longint ta, tb, dy, dm, dd;
    int sel;
    for (int i = 0; i < n; i++) begin
      cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      ta = ($urandom_range(1) == 0) ? near_instant() : rand_instant();
      tb = ($urandom_range(1) == 0) ? near_instant() : rand_instant();
      sel = $urandom_range(19);
      // Mostly in-range counts; a few full-width words and out-of-range instants.
      dy = (sel == 0) ? rand_word() : longint'($urandom_range(400)) - 200;
      dm = (sel == 1) ? rand_word() : longint'($urandom_range(4000)) - 2000;
      dd = (sel == 2) ? rand_word() : longint'($urandom_range(20000)) - 10000;
      if (sel == 3) dy = longint'($urandom_range(200000)) - 100000;
      if (sel == 4) dm = longint'($urandom_range(2400000)) - 1200000;
      if (sel == 5) ta = longint'({$urandom, $urandom}) >>> 25;
      if (sel == 6) tb = longint'({$urandom, $urandom}) >>> 25;
      send_request(cmd, ta, tb, dy, dm, dd);
    end
  endtask

  task automatic test_backpressure();
    sink_hold = hold_cnt + 200;
    src_idle_on = 1'b0;
    test_random(60);
    src_idle_on = 1'b1;
    wait_drained();
    test_random(20);
    wait_drained();
  endtask

  task automatic test_full_rate();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(150);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.cmd = '0;
    req_if.time_a = '0;
    req_if.time_b = '0;
    req_if.delta_years = '0;
    req_if.delta_months = '0;
    req_if.delta_days = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    test_full_rate();
    test_random(350);
    wait_drained();
    repeat (40) @(posedge clk_i);
    $display("Sent %0d request items and checked %0d result items,", n_sent, n_results);
    $display("covering all operations, range errors, leap days and stalls.");
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
